// ===== src/flpw_pkg.sv =====
// Package for the four-level page walker: item structs, result kind codes,
// configuration register indexes and fixed address-field constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flpw_pkg;

	// Table index width and the virtual address layout
	localparam int unsigned INDEX_BITS = 9;
	localparam int unsigned VA_BITS    = 48;
	localparam int unsigned IDX_ALL    = 4 * INDEX_BITS;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned OUT_PAGE_BITS = 40;

	// Result kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_UNEXP  = 2'd2;

	// Input functions
	localparam logic FUNC_TRANSLATE = 1'b0;
	localparam logic FUNC_ENTRY     = 1'b1;

	// Page level codes
	localparam logic [1:0] PLVL_4K = 2'd0;
	localparam logic [1:0] PLVL_2M = 2'd1;
	localparam logic [1:0] PLVL_1G = 2'd2;

	// Walk levels (awaited entry level minus one)
	localparam logic [1:0] WLVL_LAST = 2'd0;
	localparam logic [1:0] WLVL_2M   = 2'd1;
	localparam logic [1:0] WLVL_1G   = 2'd2;
	localparam logic [1:0] WLVL_ROOT = 2'd3;

	// Configuration register indexes
	localparam logic CFG_ROOT_BASE  = 1'b0;
	localparam logic CFG_WINDOW_OFF = 1'b1;

	// Entry bits
	localparam int unsigned ENT_PRESENT = 0;
	localparam int unsigned ENT_PSIZE   = 7;

	typedef struct packed {
		logic                 func;
		logic [VA_BITS-1:0]   virt_addr;
		logic [63:0]          entry_word;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [63:0]              read_addr;
		logic                     found;
		logic [OUT_PAGE_BITS-1:0] page_base;
		logic [1:0]               page_level;
	} res_item_t;

endpackage

`default_nettype wire

// ===== src/four_level_page_walker_unit.sv =====
// Top level of the four-level page walker: input register, walk decision and
// result register. Depends on flpw_pkg.
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall | cmd_item (func, virt_addr, entry_word)
//  res     | out       | res_valid/res_stall | res_item (kind, read_addr, found, ...)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while res is not stalled; each item gives one result,
// which passes through the input register and then the result register (after one
// decision and one 64-bit three-input address add).
// Reset clears the walk state, the configuration registers and both valid flags.
// A stall on res holds the result register; the input register keeps taking an
// item while the result register is free or being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_walker_unit #(
	parameter int unsigned PHYS_BITS = 40
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  flpw_pkg::cmd_item_t  cmd_item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output flpw_pkg::res_item_t  res_item,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire                  cfg_index,
	input  wire  [63:0]          cfg_data
);
	import flpw_pkg::*;

	localparam logic [63:0] PHYS_MASK   = (PHYS_BITS >= 64) ? '1 :
		((64'd1 << PHYS_BITS) - 64'd1);
	localparam logic [63:0] BASE4K_MASK = PHYS_MASK & ~64'h0000_0000_0000_0fff;
	localparam logic [63:0] BASE2M_MASK = PHYS_MASK & ~64'h0000_0000_001f_ffff;
	localparam logic [63:0] BASE1G_MASK = PHYS_MASK & ~64'h0000_0000_3fff_ffff;

	// Configuration and walk state
	logic [63:0]          root_base_q;
	logic [63:0]          window_off_q;
	logic [1:0]           walk_level_q;
	logic                 walk_busy_q;
	logic [IDX_ALL-1:0]   saved_idx_q;

	// Input register and result register
	logic                 valid_s1;
	cmd_item_t            item_s1;
	logic                 res_valid_q;
	res_item_t            res_q;

	logic                 advance;
	logic                 cmd_take;

	// Decision results
	res_item_t            res_d;
	logic [1:0]           level_d;
	logic                 busy_d;
	logic [IDX_ALL-1:0]   idx_d;
	logic [INDEX_BITS-1:0] next_idx;
	logic [1:0]           next_lvl;
	logic                 present;
	logic                 psize;

	// Handshake: result register empties or moves on, input register follows
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Index of the table that the next read goes to
	assign next_lvl = walk_level_q - 2'd1;
	always_comb begin
		unique case (next_lvl)
			WLVL_LAST: next_idx = saved_idx_q[INDEX_BITS-1:0];
			WLVL_2M:   next_idx = saved_idx_q[2*INDEX_BITS-1:INDEX_BITS];
			WLVL_1G:   next_idx = saved_idx_q[3*INDEX_BITS-1:2*INDEX_BITS];
			default:   next_idx = saved_idx_q[4*INDEX_BITS-1:3*INDEX_BITS];
		endcase
	end

	assign present = item_s1.entry_word[ENT_PRESENT];
	assign psize   = item_s1.entry_word[ENT_PSIZE];

	// Walk decision for the item in the input register
	always_comb begin
		res_d   = '0;
		level_d = walk_level_q;
		busy_d  = walk_busy_q;
		idx_d   = saved_idx_q;
		if (item_s1.func == FUNC_TRANSLATE) begin
			idx_d          = item_s1.virt_addr[VA_BITS-1:PAGE_SHIFT];
			level_d        = WLVL_ROOT;
			busy_d         = 1'b1;
			res_d.kind     = KIND_READ;
			res_d.read_addr = root_base_q + {52'd0,
				item_s1.virt_addr[VA_BITS-1:VA_BITS-INDEX_BITS], 3'b000};
		end else if (!walk_busy_q) begin
			res_d.kind = KIND_UNEXP;
		end else begin
			priority if (!present) begin
				res_d.kind = KIND_DONE;
				busy_d     = 1'b0;
				level_d    = WLVL_LAST;
			end else if (walk_level_q == WLVL_LAST) begin
				res_d.kind      = KIND_DONE;
				res_d.found     = 1'b1;
				res_d.page_base = OUT_PAGE_BITS'(item_s1.entry_word & BASE4K_MASK);
				res_d.page_level = PLVL_4K;
				busy_d          = 1'b0;
				level_d         = WLVL_LAST;
			end else if (walk_level_q == WLVL_1G && psize) begin
				res_d.kind      = KIND_DONE;
				res_d.found     = 1'b1;
				res_d.page_base = OUT_PAGE_BITS'(item_s1.entry_word & BASE1G_MASK);
				res_d.page_level = PLVL_1G;
				busy_d          = 1'b0;
				level_d         = WLVL_LAST;
			end else if (walk_level_q == WLVL_2M && psize) begin
				res_d.kind      = KIND_DONE;
				res_d.found     = 1'b1;
				res_d.page_base = OUT_PAGE_BITS'(item_s1.entry_word & BASE2M_MASK);
				res_d.page_level = PLVL_2M;
				busy_d          = 1'b0;
				level_d         = WLVL_LAST;
			end else begin
				// pointer entry: descend one level
				level_d         = next_lvl;
				res_d.kind      = KIND_READ;
				res_d.read_addr = (item_s1.entry_word & BASE4K_MASK) + window_off_q +
					{52'd0, next_idx, 3'b000};
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_base_q  <= '0;
			window_off_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROOT_BASE:  root_base_q  <= cfg_data;
				CFG_WINDOW_OFF: window_off_q <= cfg_data;
			endcase
		end
	end

	// Walk state, updated as an item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_level_q <= WLVL_LAST;
			walk_busy_q  <= 1'b0;
			saved_idx_q  <= '0;
		end else if (advance) begin
			walk_level_q <= level_d;
			walk_busy_q  <= busy_d;
			saved_idx_q  <= idx_d;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= cmd_item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Checks
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		!walk_busy_q |-> walk_level_q == WLVL_LAST)
		else $error("idle walker with nonzero level");

	a_no_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.found |-> res_q.page_base == '0 && res_q.page_level == PLVL_4K)
		else $error("page fields set without a mapping");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind != KIND_DONE |-> !res_q.found)
		else $error("found set on a result that is not a finished walk");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with room free");

endmodule

`default_nettype wire
